>>> sv/lszg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lszg_pkg: shared types and constants for the laser scan safety zone gate
// Payload structs, configuration register codes and the sine table generator.
// ----------------------------------------------------------------------------
package lszg_pkg;

  // Defaults for the top level parameters
  localparam int MAX_SAMPLES_DEF     = 1024;
  localparam int SINE_TABLE_BITS_DEF = 10;

  // Fixed field widths
  localparam int RANGE_W = 16;
  localparam int SPEED_W = 16;
  localparam int ANGLE_W = 16;
  localparam int CNT_W   = 11;
  localparam int OFS_W   = 16;
  localparam int HALF_W  = 15;
  localparam int MAG_W   = 15;               // Q14 magnitude, up to 16384
  localparam int PROD_W  = RANGE_W + MAG_W;  // range times magnitude
  localparam int PT_W    = 18;               // rounded point plus offset, signed
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 16;

  localparam logic [CNT_W-1:0] INDEX_MAX = {CNT_W{1'b1}};

  // Q30 constants for the table generator
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q14_ONE     = 64'd16384;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_ENABLE      = 3'd0,
    REG_ANGLE_START = 3'd1,
    REG_ANGLE_STEP  = 3'd2,
    REG_SCAN_SAMPLE = 3'd3,
    REG_MOUNT_X     = 3'd4,
    REG_MOUNT_Y     = 3'd5,
    REG_HALF_WIDTH  = 3'd6,
    REG_HALF_LENGTH = 3'd7
  } cfg_reg_t;

  // Register file contents
  typedef struct packed {
    logic                     enable;
    logic [ANGLE_W-1:0]       angle_start;
    logic [ANGLE_W-1:0]       angle_step;
    logic [CNT_W-1:0]         scan_samples;
    logic signed [OFS_W-1:0]  mount_offset_x;
    logic signed [OFS_W-1:0]  mount_offset_y;
    logic [HALF_W-1:0]        half_width;
    logic [HALF_W-1:0]        half_length;
  } cfg_t;

  // Input transaction
  typedef struct packed {
    logic [RANGE_W-1:0]        range_mm;
    logic                      last_sample;
    logic signed [SPEED_W-1:0] speed_in;
    logic signed [SPEED_W-1:0] turn_in;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic signed [SPEED_W-1:0] speed_out;
    logic signed [SPEED_W-1:0] turn_out;
    logic                      scan_clear;
    logic                      count_mismatch;
  } out_item_t;

  // Classified sample handed from front to back
  typedef struct packed {
    logic [RANGE_W-1:0]        range_mm;
    logic [MAG_W-1:0]          sin_mag;
    logic                      sin_neg;
    logic [MAG_W-1:0]          cos_mag;
    logic                      cos_neg;
    logic                      last_sample;
    logic                      mismatch;
    logic signed [SPEED_W-1:0] speed_in;
    logic signed [SPEED_W-1:0] turn_in;
  } q_item_t;

  // sin(pi/2 * j / quarter) in Q14, Taylor series to x^11 in Q30; used at elaboration
  function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned j,
                                                    input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (HALF_PI_Q30 * 64'(j)) >> (tbits - 2);
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    s  = (s + 64'd32768) >> 16;
    if (s > Q14_ONE) begin
      s = Q14_ONE;
    end
    return MAG_W'(s);
  endfunction

endpackage
`default_nettype wire

>>> sv/laser_scan_safety_zone_gate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// laser_scan_safety_zone_gate: rectangular protective field check on a scan
// Gates commanded speeds with a per-scan intrusion test of laser samples.
// ----------------------------------------------------------------------------
// Takes one range sample per clock cycle, sustained, as long as the result
// queue is drained; a sample is classified in the cycle it is accepted, is
// registered in a two-entry sample queue and then in the multiply stage, and
// the result of a scan is written from that stage into the result queue.
// Only the last sample of a scan produces a transaction; a full two-entry
// result queue stalls the multiply stage and, through the sample queue, the
// intake. Configuration registers are to be written only while no scan is in
// flight; the block itself does not enforce this.
module laser_scan_safety_zone_gate
  import lszg_pkg::*;
#(
  parameter int MAX_SAMPLES     = MAX_SAMPLES_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  input  wire logic              in_push,
  input  wire in_item_t          in_data,
  output logic                   in_full,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output out_item_t              out_data
);
  cfg_t    cfg_r, cfg_nxt;
  logic    q_full, q_empty, q_push, q_pop;
  q_item_t q_wdata, q_rdata;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_ENABLE:      cfg_nxt.enable         = cfg_wdata[0];
        REG_ANGLE_START: cfg_nxt.angle_start    = cfg_wdata;
        REG_ANGLE_STEP:  cfg_nxt.angle_step     = cfg_wdata;
        REG_SCAN_SAMPLE: cfg_nxt.scan_samples   = cfg_wdata[CNT_W-1:0];
        REG_MOUNT_X:     cfg_nxt.mount_offset_x = cfg_wdata;
        REG_MOUNT_Y:     cfg_nxt.mount_offset_y = cfg_wdata;
        REG_HALF_WIDTH:  cfg_nxt.half_width     = cfg_wdata[HALF_W-1:0];
        REG_HALF_LENGTH: cfg_nxt.half_length    = cfg_wdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable         <= 1'b0;
      cfg_r.angle_start    <= '0;
      cfg_r.angle_step     <= '0;
      cfg_r.scan_samples   <= CNT_W'(1);
      cfg_r.mount_offset_x <= '0;
      cfg_r.mount_offset_y <= '0;
      cfg_r.half_width     <= HALF_W'(310);
      cfg_r.half_length    <= HALF_W'(565);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lszg_front #(
    .MAX_SAMPLES    (MAX_SAMPLES),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_push(in_push),
    .in_data(in_data),
    .in_full(in_full),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_wdata)
  );

  // decoupling queue between intake and projection
  lszg_fifo #(
    .WIDTH($bits(q_item_t)),
    .DEPTH(2)
  ) u_sample_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  lszg_back #(
    .OUT_DEPTH(2)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_item   (q_rdata),
    .q_pop    (q_pop),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

>>> sv/lszg_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lszg_fifo: small synchronous queue
// Register-based FIFO with full/empty flags; head entry is read directly.
// ----------------------------------------------------------------------------
module lszg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

>>> sv/lszg_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lszg_front: sample intake and classification
// Tracks beam angle and sample count, looks up sine and cosine, and flags
// a count mismatch on the last sample of a scan.
// ----------------------------------------------------------------------------
module lszg_front
  import lszg_pkg::*;
#(
  parameter int MAX_SAMPLES     = MAX_SAMPLES_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  input  wire logic     in_push,
  input  wire in_item_t in_data,
  output logic          in_full,
  input  wire logic     q_full,
  output logic          q_push,
  output q_item_t       q_item
);
  localparam int TB      = SINE_TABLE_BITS;
  localparam int QUARTER = 1 << (TB - 2);
  localparam int QI_W    = TB - 1;       // indexes 0..QUARTER
  localparam int SMAX_W  = CNT_W + 2;
  localparam logic [SMAX_W-1:0] SMAX = SMAX_W'(MAX_SAMPLES);

  // quarter-wave sine table, constant
  logic [MAG_W-1:0] qtab [QUARTER + 1];
  for (genvar k = 0; k <= QUARTER; k++) begin : g_qtab
    assign qtab[k] = quarter_sine(k, TB);
  end

  logic [CNT_W-1:0]   sample_index_r, sample_index_nxt;
  logic [ANGLE_W-1:0] beam_angle_r, beam_angle_nxt;
  logic [ANGLE_W-1:0] angle;
  logic [TB-1:0]      tidx [2];
  logic [MAG_W-1:0]   mag  [2];
  logic               neg  [2];
  logic [CNT_W-1:0]   count_inc;
  logic               accept;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign q_push  = accept;

  assign angle   = (sample_index_r == '0) ? cfg.angle_start : beam_angle_r;
  assign tidx[0] = angle[ANGLE_W-1 -: TB];
  assign tidx[1] = angle[ANGLE_W-1 -: TB] + TB'(QUARTER);

  // fold table index by quadrant: odd quadrants mirror, upper half negates
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      if (tidx[p][TB-2]) begin
        mag[p] = qtab[QI_W'(QUARTER) - {1'b0, tidx[p][TB-3:0]}];
      end else begin
        mag[p] = qtab[{1'b0, tidx[p][TB-3:0]}];
      end
      neg[p] = tidx[p][TB-1];
    end
  end

  // saturating sample count after this sample
  assign count_inc = (sample_index_r == INDEX_MAX) ? INDEX_MAX : sample_index_r + 1'b1;

  always_comb begin
    q_item.range_mm    = in_data.range_mm;
    q_item.sin_mag     = mag[0];
    q_item.sin_neg     = neg[0];
    q_item.cos_mag     = mag[1];
    q_item.cos_neg     = neg[1];
    q_item.last_sample = in_data.last_sample;
    q_item.mismatch    = (cfg.scan_samples == '0) ||
                         ({2'b00, cfg.scan_samples} > SMAX) ||
                         (count_inc != cfg.scan_samples);
    q_item.speed_in    = in_data.speed_in;
    q_item.turn_in     = in_data.turn_in;
  end

  // scan state
  always_comb begin
    sample_index_nxt = sample_index_r;
    beam_angle_nxt   = beam_angle_r;
    if (accept) begin
      beam_angle_nxt   = angle + cfg.angle_step;
      sample_index_nxt = in_data.last_sample ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_index_r <= '0;
      beam_angle_r   <= '0;
    end else begin
      sample_index_r <= sample_index_nxt;
      beam_angle_r   <= beam_angle_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/lszg_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lszg_back: point projection, zone check and result generation
// Multiplies range by sine/cosine, rounds, adds mount offset, tests the
// rectangle and emits the gated speeds into the result queue.
// ----------------------------------------------------------------------------
module lszg_back
  import lszg_pkg::*;
#(
  parameter int OUT_DEPTH = 2
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      q_empty,
  input  wire q_item_t   q_item,
  output logic           q_pop,
  input  wire logic      out_pop,
  output logic           out_empty,
  output out_item_t      out_data
);
  // product stage
  logic                      s1_valid_r, s1_valid_nxt;
  logic [PROD_W-1:0]         s1_px_r, s1_py_r;
  logic                      s1_xneg_r, s1_yneg_r;
  logic                      s1_last_r, s1_mis_r;
  logic signed [SPEED_W-1:0] s1_speed_r, s1_turn_r;

  logic              intr_r, intr_nxt;
  logic              out_full, out_push, advance;
  out_item_t         res;
  logic [PROD_W-1:0] rnd_x, rnd_y;
  logic signed [PT_W-1:0] sx, sy, ptx, pty;
  logic [PT_W-1:0]   ax, ay;
  logic              in_zone, hit, clear;

  // the stage stalls only when a result cannot be queued
  assign advance = !(s1_valid_r && s1_last_r && out_full);
  assign q_pop   = advance && !q_empty;
  assign s1_valid_nxt = advance ? !q_empty : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_px_r    <= PROD_W'(q_item.range_mm) * PROD_W'(q_item.sin_mag);
      s1_py_r    <= PROD_W'(q_item.range_mm) * PROD_W'(q_item.cos_mag);
      s1_xneg_r  <= q_item.sin_neg;
      s1_yneg_r  <= q_item.cos_neg;
      s1_last_r  <= q_item.last_sample;
      s1_mis_r   <= q_item.mismatch;
      s1_speed_r <= q_item.speed_in;
      s1_turn_r  <= q_item.turn_in;
    end
  end

  // round to mm, apply sign and offset, test the rectangle
  always_comb begin
    rnd_x   = s1_px_r + PROD_W'(8192);
    rnd_y   = s1_py_r + PROD_W'(8192);
    sx      = s1_xneg_r ? -$signed({2'b00, rnd_x[29:14]}) : $signed({2'b00, rnd_x[29:14]});
    sy      = s1_yneg_r ? -$signed({2'b00, rnd_y[29:14]}) : $signed({2'b00, rnd_y[29:14]});
    ptx     = sx + PT_W'(cfg.mount_offset_x);
    pty     = sy + PT_W'(cfg.mount_offset_y);
    ax      = ptx[PT_W-1] ? PT_W'(-ptx) : PT_W'(ptx);
    ay      = pty[PT_W-1] ? PT_W'(-pty) : PT_W'(pty);
    in_zone = (ax < PT_W'(cfg.half_width)) && (ay < PT_W'(cfg.half_length));
    hit     = intr_r || in_zone;
    clear   = !s1_mis_r && !hit;
  end

  // intrusion flag accumulates over the scan, cleared after the last sample
  always_comb begin
    intr_nxt = intr_r;
    if (s1_valid_r && advance) begin
      intr_nxt = s1_last_r ? 1'b0 : hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intr_r <= 1'b0;
    end else begin
      intr_r <= intr_nxt;
    end
  end

  // result transaction
  always_comb begin
    res.speed_out      = (cfg.enable && clear) ? s1_speed_r : '0;
    res.turn_out       = (cfg.enable && clear) ? s1_turn_r : '0;
    res.scan_clear     = clear;
    res.count_mismatch = s1_mis_r;
  end

  assign out_push = s1_valid_r && s1_last_r && !out_full;

  lszg_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (out_push),
    .wdata(res),
    .full (out_full),
    .pop  (out_pop),
    .rdata(out_data),
    .empty(out_empty)
  );

endmodule
`default_nettype wire

>>> sv/lszg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lszg_checker: port-level checks for the safety zone gate
// Watches the result queue and the gating rules on the top level ports.
// ----------------------------------------------------------------------------
module lszg_checker
  import lszg_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_empty,
  input wire logic      out_pop,
  input wire out_item_t out_data
);

  // nothing is waiting right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // a scan that is not clear never passes motion
  a_gate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.scan_clear) |->
      (out_data.speed_out == '0 && out_data.turn_out == '0))
    else $error("speeds passed on a scan that is not clear");

  // a count mismatch is never reported as clear
  a_mismatch_not_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.count_mismatch) |-> !out_data.scan_clear)
    else $error("mismatched scan reported clear");

  // a waiting result holds until taken
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed or vanished");

endmodule

bind laser_scan_safety_zone_gate lszg_checker u_lszg_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_empty(out_empty),
  .out_pop  (out_pop),
  .out_data (out_data)
);
`default_nettype wire

>>> bench/tb_laser_scan_safety_zone_gate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_laser_scan_safety_zone_gate: self-checking bench for the safety zone gate
// Streams laser scans through the queue-style input, predicts each per-scan
// speed command in a scoreboard, and checks every popped transaction.
// ----------------------------------------------------------------------------
// A short directed part (clear scan, intrusion, short and long scans, disabled
// gate, zero expected count) is followed by randomized register settings, each
// run with mostly well-formed scans and some with a wrong length.
module tb_laser_scan_safety_zone_gate;
  import lszg_pkg::*;

  localparam int IDLE_LIMIT = 2000;   // cycles without any transaction
  localparam int DRAIN_WAIT = 8;      // pipeline depth plus margin

  // Scoreboard: predicts the gated command of each scan and checks results
  class gate_scoreboard;
    localparam int TABLE_BITS  = 10;
    localparam int TABLE_SIZE  = 1 << TABLE_BITS;
    localparam int QUARTER     = TABLE_SIZE / 4;
    localparam int MAX_SCAN    = 1024;
    localparam int COUNT_CAP   = 2047;
    localparam int PRINT_CAP   = 100;
    localparam bit [63:0] Q30         = 64'd1 << 30;
    localparam bit [63:0] HALF_PI_Q30 = 64'd1686629713;

    int sine_q14[TABLE_SIZE];

    // register copies
    bit          en;
    logic [15:0] angle_start;
    logic [15:0] angle_step;
    int          scan_len;
    int          mount_x;
    int          mount_y;
    int          half_w;
    int          half_l;

    // scan state
    int          beam_count;
    logic [15:0] next_angle;
    bit          hit;

    out_item_t   expected_cmds[$];
    int          errors;
    int          n_samples;
    int          n_scans;
    int          n_passed;
    int          n_intruded;
    int          n_mismatch;

    function new();
      int quad;
      int j;
      int v;
      for (int k = 0; k < TABLE_SIZE; k++) begin
        quad = k / QUARTER;
        j = k % QUARTER;
        v = (quad % 2 == 1) ? q14_sine_quarter(QUARTER - j) : q14_sine_quarter(j);
        sine_q14[k] = (quad >= 2) ? -v : v;
      end
      en = 0;
      angle_start = '0;
      angle_step = '0;
      scan_len = 1;
      mount_x = 0;
      mount_y = 0;
      half_w = 310;
      half_l = 565;
      beam_count = 0;
      next_angle = '0;
      hit = 0;
    endfunction

    // Q14 sine over the first quarter turn, odd Taylor series in Q30
    function int q14_sine_quarter(int unsigned j);
      bit [63:0]   arg;
      bit [63:0]   arg_sq;
      bit [63:0]   series;
      bit [63:0]   val;
      int unsigned divs[5] = '{110, 72, 42, 20, 6};
      arg = (HALF_PI_Q30 * 64'(j)) / QUARTER;
      arg_sq = (arg * arg) >> 30;
      series = Q30;
      foreach (divs[i]) series = Q30 - (((arg_sq * series) >> 30) / divs[i]);
      val = (((arg * series) >> 30) + 64'd32768) >> 16;
      if (val > 64'd16384) val = 64'd16384;
      return int'(val);
    endfunction

    // range times Q14 factor, rounded half away from zero
    function int scale_range(logic [15:0] r, int f);
      int unsigned mag;
      int unsigned prod;
      mag = (f < 0) ? -f : f;
      prod = (r * mag + 32'd8192) >> 14;
      return (f < 0) ? -int'(prod) : int'(prod);
    endfunction

    function void set_reg(cfg_reg_t r, logic [15:0] v);
      case (r)
        REG_ENABLE:      en = v[0];
        REG_ANGLE_START: angle_start = v;
        REG_ANGLE_STEP:  angle_step = v;
        REG_SCAN_SAMPLE: scan_len = int'(v[10:0]);
        REG_MOUNT_X:     mount_x = int'($signed(v));
        REG_MOUNT_Y:     mount_y = int'($signed(v));
        REG_HALF_WIDTH:  half_w = int'(v[14:0]);
        REG_HALF_LENGTH: half_l = int'(v[14:0]);
        default: ;
      endcase
    endfunction

    // Accepted input transaction: run the zone test, close the scan on last
    function void note_sample(in_item_t s);
      logic [15:0] ang;
      int          slot;
      int          px;
      int          py;
      bit          mism;
      bit          clr;
      out_item_t   cmd;
      n_samples++;
      ang = (beam_count == 0) ? angle_start : next_angle;
      slot = int'(ang >> (16 - TABLE_BITS));
      px = scale_range(s.range_mm, sine_q14[slot]) + mount_x;
      py = scale_range(s.range_mm, sine_q14[(slot + QUARTER) % TABLE_SIZE]) + mount_y;
      if (px < 0) px = -px;
      if (py < 0) py = -py;
      if (px < half_w && py < half_l) hit = 1;
      if (beam_count < COUNT_CAP) beam_count++;
      next_angle = ang + angle_step;
      if (!s.last_sample) return;

      mism = (scan_len == 0) || (scan_len > MAX_SCAN) || (beam_count != scan_len);
      clr = !mism && !hit;
      cmd.speed_out = (en && clr) ? s.speed_in : '0;
      cmd.turn_out = (en && clr) ? s.turn_in : '0;
      cmd.scan_clear = clr;
      cmd.count_mismatch = mism;
      expected_cmds = {expected_cmds, cmd};
      n_scans++;
      if (en && clr) n_passed++;
      if (hit) n_intruded++;
      if (mism) n_mismatch++;
      beam_count = 0;
      hit = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Popped result transaction against the oldest prediction
    task check_result(out_item_t got);
      out_item_t want;
      if (expected_cmds.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = expected_cmds.pop_front();
      if (got.speed_out !== want.speed_out)
        report($sformatf("speed_out %0d, expected %0d", got.speed_out, want.speed_out));
      if (got.turn_out !== want.turn_out)
        report($sformatf("turn_out %0d, expected %0d", got.turn_out, want.turn_out));
      if (got.scan_clear !== want.scan_clear)
        report($sformatf("scan_clear %b, expected %b", got.scan_clear, want.scan_clear));
      if (got.count_mismatch !== want.count_mismatch)
        report($sformatf("count_mismatch %b, expected %b",
                         got.count_mismatch, want.count_mismatch));
    endtask
  endclass

  logic              clk;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic              in_push = 1'b0;
  in_item_t          in_data = '0;
  logic              in_full;
  logic              out_empty;
  logic              out_pop = 1'b0;
  out_item_t         out_data;

  gate_scoreboard sb = new();

  int burst_left = 0;
  bit steady = 0;
  int pop_mode = 0;
  int pop_span = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int n_settings = 0;

  laser_scan_safety_zone_gate dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Monitor and watchdog: sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) sb.note_sample(in_data);
      if (out_pop && !out_empty) sb.check_result(out_data);
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Result side: free-running, random, or long stalls, switching modes
  always @(negedge clk) begin
    if (pop_span == 0) begin
      pop_mode = $urandom_range(0, 3);
      pop_span = $urandom_range(20, 80);
    end else begin
      pop_span--;
    end
    case (pop_mode)
      0, 1: out_pop <= 1'b1;
      2: out_pop <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_left == 0) begin
          out_pop <= 1'b1;
          stall_left = $urandom_range(1, 12);
        end else begin
          out_pop <= 1'b0;
          stall_left--;
        end
      end
    endcase
  end

  // One sample transaction, paced in bursts with random gaps
  task automatic send_sample(logic [15:0] rng, bit fin,
                             logic signed [15:0] spd, logic signed [15:0] trn);
    in_item_t it;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    it.range_mm = rng;
    it.last_sample = fin;
    it.speed_in = spd;
    it.turn_in = trn;
    in_data <= it;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  // Directed scan: constant range, optional zero-range beam at index hole
  task automatic send_scan(int len, logic [15:0] rng, int hole,
                           logic signed [15:0] spd, logic signed [15:0] trn);
    for (int i = 0; i < len; i++)
      send_sample((i == hole) ? 16'd0 : rng, i == len - 1, spd, trn);
  endtask

  function automatic logic [15:0] pick_range();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 16'($urandom_range(2500, 65535));
      6, 7: return 16'($urandom_range(0, 1500));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Random scan: mostly the configured length, sometimes a wrong one
  task automatic random_scan(output int len);
    bool_len: begin
    end
    if (sb.scan_len >= 1 && sb.scan_len <= 1024 && $urandom_range(0, 4) != 0) begin
      len = sb.scan_len;
    end else begin
      len = $urandom_range(1, ((sb.scan_len >= 1 && sb.scan_len <= 12) ?
                               sb.scan_len : 8) + 3);
    end
    for (int i = 0; i < len; i++)
      send_sample(pick_range(), i == len - 1, 16'($urandom), 16'($urandom));
  endtask

  // Let every scan in flight finish before touching the registers
  task automatic wait_idle();
    in_push <= 1'b0;
    while (sb.expected_cmds.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic apply_config(bit en, int start, int step, int samples,
                              int mx, int my, int hw, int hl);
    logic [15:0] vals [8];
    vals[REG_ENABLE] = 16'(en);
    vals[REG_ANGLE_START] = 16'(start);
    vals[REG_ANGLE_STEP] = 16'(step);
    vals[REG_SCAN_SAMPLE] = 16'(samples);
    vals[REG_MOUNT_X] = 16'(mx);
    vals[REG_MOUNT_Y] = 16'(my);
    vals[REG_HALF_WIDTH] = 16'(hw);
    vals[REG_HALF_LENGTH] = 16'(hl);
    wait_idle();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= cfg_reg_t'(i);
      cfg_wdata <= vals[i];
      sb.set_reg(cfg_reg_t'(i), vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Main sequence
  initial begin
    int len;
    int sent;
    bit en;
    int start;
    int step;
    int samples;
    int mx;
    int my;
    int hw;
    int hl;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: quarter-turn beams, default rectangle
    apply_config(1, 0, 16384, 4, 0, 0, 310, 565);
    send_scan(4, 16'hFFFF, -1, 16'sh7FFF, -16'sh8000);   // clear, speeds pass
    send_scan(4, 16'd40000, 1, -16'sh8000, 16'sh7FFF);   // beam at the sensor intrudes
    send_scan(3, 16'd40000, -1, 16'sh1234, 16'sh4321);   // scan too short
    send_scan(5, 16'd40000, -1, 16'sh1234, 16'sh4321);   // scan too long
    apply_config(0, 0, 16384, 4, 0, 0, 310, 565);
    send_scan(4, 16'd40000, -1, 16'sh7FFF, 16'sh7FFF);   // clear, gate disabled
    apply_config(1, 0, 16384, 0, 0, 0, 310, 565);
    send_scan(1, 16'd40000, -1, 16'sh0100, 16'sh0200);   // zero expected count

    // Random register settings, extremes forced in some
    for (int p = 0; p < 10; p++) begin
      en = (p == 4) ? 1'b0 : ($urandom_range(0, 5) != 0);
      start = (p == 5) ? 65535 : $urandom_range(0, 65535);
      step = (p == 0) ? 65535 : (p == 6) ? 0 :
             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4096);
      samples = (p == 2) ? 2047 : (p == 7) ? 1025 : (p == 3) ? 1 : $urandom_range(1, 10);
      mx = (p == 1) ? -32768 : (p == 8) ? 32767 : $urandom_range(0, 1000) - 500;
      my = (p == 1) ? 32767 : (p == 8) ? -32768 : $urandom_range(0, 1000) - 500;
      hw = (p == 0) ? 0 : (p == 1 || p == 8) ? 32767 : $urandom_range(0, 1500);
      hl = (p == 0) ? 0 : (p == 1 || p == 8) ? 32767 : $urandom_range(0, 2000);
      apply_config(en, start, step, samples, mx, my, hw, hl);
      steady = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < 45) begin
        random_scan(len);
        sent += len;
      end
    end
    steady = 0;

    // Drain and settle
    in_push <= 1'b0;
    while (sb.expected_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.expected_cmds.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.expected_cmds.size()));

    $display("covered %0d samples in %0d scans over %0d register settings",
             sb.n_samples, sb.n_scans, n_settings);
    $display("scans passing speeds: %0d, with intrusion: %0d, with count mismatch: %0d",
             sb.n_passed, sb.n_intruded, sb.n_mismatch);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
